### rtl/core/fmtp_pkg.sv
// ---------------------------------------------------------------------------
// fmtp_pkg: shared types and constants
// Operation codes and the command and status bundles for the factorial
// prime-power divisor core.
// ---------------------------------------------------------------------------
`default_nettype none

package fmtp_pkg;

  localparam int MAX_N_DEF = 131072;
  localparam int NW        = 17;
  localparam int MW        = 32;
  localparam logic [MW-1:0] MOD_RESET = 32'd10000019;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_FILL,
    OP_SV_JSET,
    OP_SV_MARK,
    OP_SV_INEXT,
    OP_LOAD,
    OP_PNEXT,
    OP_QINIT,
    OP_DIV_Q,
    OP_QSTEP,
    OP_DIV_K,
    OP_KSET,
    OP_FOUND,
    OP_MUL_BASE,
    OP_BSET,
    OP_MUL_RB,
    OP_RSET,
    OP_MUL_BB,
    OP_BSQ,
    OP_MUL_ACC,
    OP_ACCSET,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   rd_i;
  } ctl_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic i_sq_lt;
    logic j_ge;
    logic flag;
    logic p_gt_n;
    logic quot_zero;
    logic e_ge_t;
    logic m_small;
    logic k_zero;
    logic k_odd;
    logic div_done;
    logic mul_done;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/fmtp_div.sv
// ---------------------------------------------------------------------------
// fmtp_div: restoring divider
// One quotient bit per cycle; done rises with the last quotient bit.
// ---------------------------------------------------------------------------
`default_nettype none

module fmtp_div #(
  parameter int W = 17
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic      [W-1:0] quot,
  output logic              done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule

`default_nettype wire

### rtl/core/fmtp_mulmod.sv
// ---------------------------------------------------------------------------
// fmtp_mulmod: shift-add modular multiplier
// Computes x*y mod m for y < m, one bit of x at a time, MSB first (double, then add).
// ---------------------------------------------------------------------------
`default_nettype none

module fmtp_mulmod #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] x,
  input  wire logic [W-1:0] y,
  input  wire logic [W-1:0] m,
  output logic      [W-1:0] res,
  output logic              done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  x_r;
  logic [W-1:0]  y_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  r_r;
  logic [CW-1:0] cnt_r;
  logic          phase_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    dbl;
  logic [W:0]    sum;
  logic [W:0]    sel;
  logic [W:0]    red;

  assign dbl = {r_r, 1'b0};
  assign sum = {1'b0, r_r} + {1'b0, y_r};
  assign sel = phase_r ? sum : dbl;
  assign red = (sel >= {1'b0, m_r}) ? sel - {1'b0, m_r} : sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
        cnt_r   <= CW'(W);
      end else if (busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
      m_r <= m;
      r_r <= '0;
    end else if (busy_r) begin
      if (!phase_r) begin
        r_r <= red[W-1:0];
      end else begin
        if (x_r[W-1]) begin
          r_r <= red[W-1:0];
        end
        x_r <= {x_r[W-2:0], 1'b0};
      end
    end
  end

  assign res  = r_r;
  assign done = done_r;

endmodule

`default_nettype wire

### rtl/core/fmtp_dp.sv
// ---------------------------------------------------------------------------
// fmtp_dp: datapath
// Primality table, item registers, shared divider and modular multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module fmtp_dp import fmtp_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [NW-1:0] in_n_value,
  input  wire logic [NW-1:0] in_power_t,
  input  wire logic          cfg_we,
  input  wire logic [MW-1:0] cfg_wdata,
  input  wire ctl_cmd_t      cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  output logic               out_found,
  output logic      [MW-1:0] out_product
);

  localparam int AW  = $clog2(MAX_N);
  localparam int PW  = AW + 1;
  localparam int SQW = 2 * AW;

  logic          mem [MAX_N];
  logic          flag_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          mem_wd;
  logic [AW-1:0] rd_a;

  logic [PW-1:0] fill_cnt_r;
  logic [AW-1:0] i_r;
  logic [PW-1:0] j_r;
  logic [SQW-1:0] i_sq;
  logic [MW-1:0] mod_r;
  logic          out_valid_r;

  logic [NW-1:0] n_r;
  logic [NW-1:0] t_r;
  logic [MW-1:0] m_r;
  logic [PW-1:0] p_r;
  logic [NW-1:0] q_r;
  logic [NW-1:0] e_r;
  logic [NW-1:0] k_r;
  logic [MW-1:0] acc_r;
  logic [MW-1:0] r_r;
  logic [MW-1:0] b_r;
  logic          found_r;
  logic          out_found_r;
  logic [MW-1:0] out_product_r;

  logic          div_start;
  logic [NW-1:0] div_num;
  logic [NW-1:0] div_den;
  logic [NW-1:0] div_quot;
  logic          div_done;
  logic          mul_start;
  logic [MW-1:0] mul_x;
  logic [MW-1:0] mul_y;
  logic [MW-1:0] mul_res;
  logic          mul_done;

  assign i_sq   = SQW'(i_r) * SQW'(i_r);
  assign mem_we = (cmd.op == OP_FILL) || (cmd.op == OP_SV_MARK);
  assign mem_wa = (cmd.op == OP_FILL) ? fill_cnt_r[AW-1:0] : j_r[AW-1:0];
  assign mem_wd = (cmd.op == OP_FILL) && (fill_cnt_r >= PW'(2));
  assign rd_a   = cmd.rd_i ? i_r : p_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    flag_r <= mem[rd_a];
  end

  assign div_start = (cmd.op == OP_DIV_Q) || (cmd.op == OP_DIV_K);
  assign div_num   = (cmd.op == OP_DIV_Q) ? q_r : e_r;
  assign div_den   = (cmd.op == OP_DIV_Q) ? NW'(p_r) : t_r;

  fmtp_div #(.W(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

  always_comb begin
    mul_start = 1'b1;
    mul_x     = r_r;
    mul_y     = b_r;
    case (cmd.op)
      OP_MUL_BASE: begin
        mul_x = MW'(p_r);
        mul_y = MW'(1);
      end
      OP_MUL_RB: begin
        mul_x = r_r;
        mul_y = b_r;
      end
      OP_MUL_BB: begin
        mul_x = b_r;
        mul_y = b_r;
      end
      OP_MUL_ACC: begin
        mul_x = acc_r;
        mul_y = r_r;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  fmtp_mulmod #(.W(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (m_r),
    .res   (mul_res),
    .done  (mul_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      i_r         <= AW'(2);
      mod_r       <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT);
      if (cfg_we) begin
        mod_r <= cfg_wdata;
      end
      if (cmd.op == OP_FILL) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
      end
      if (cmd.op == OP_SV_INEXT) begin
        i_r <= i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SV_JSET: j_r <= PW'(i_sq);
      OP_SV_MARK: j_r <= j_r + PW'(i_r);
      OP_LOAD: begin
        n_r     <= (32'(in_n_value) > 32'(MAX_N - 1)) ? NW'(MAX_N - 1) : in_n_value;
        t_r     <= (in_power_t == '0) ? NW'(1) : in_power_t;
        m_r     <= mod_r;
        acc_r   <= (mod_r < MW'(2)) ? '0 : MW'(1);
        found_r <= 1'b0;
        p_r     <= PW'(2);
      end
      OP_PNEXT: p_r <= p_r + 1'b1;
      OP_QINIT: begin
        q_r <= n_r;
        e_r <= '0;
      end
      OP_QSTEP: begin
        q_r <= div_quot;
        e_r <= e_r + div_quot;
      end
      OP_KSET: begin
        k_r     <= div_quot;
        found_r <= 1'b1;
        r_r     <= MW'(1);
      end
      OP_FOUND: begin
        found_r <= 1'b1;
        p_r     <= p_r + 1'b1;
      end
      OP_BSET: b_r <= mul_res;
      OP_RSET: r_r <= mul_res;
      OP_BSQ: begin
        b_r <= mul_res;
        k_r <= k_r >> 1;
      end
      OP_ACCSET: begin
        acc_r <= mul_res;
        p_r   <= p_r + 1'b1;
      end
      OP_EMIT: begin
        out_found_r   <= found_r;
        out_product_r <= found_r ? acc_r : '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.fill_last = (fill_cnt_r == PW'(MAX_N - 1));
    stat.i_sq_lt   = {1'b0, i_sq} < (SQW + 1)'(MAX_N);
    stat.j_ge      = (j_r >= PW'(MAX_N));
    stat.flag      = flag_r;
    stat.p_gt_n    = (32'(p_r) > 32'(n_r));
    stat.quot_zero = (div_quot == '0);
    stat.e_ge_t    = (e_r >= t_r);
    stat.m_small   = (m_r < MW'(2));
    stat.k_zero    = (k_r == '0);
    stat.k_odd     = k_r[0];
    stat.div_done  = div_done;
    stat.mul_done  = mul_done;
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_product = out_product_r;

`ifndef ASSERT_OFF
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_product_r == '0)
    else $error("not-found result carries a nonzero product");

  a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done && (m_r >= MW'(2)) |-> mul_res < m_r)
    else $error("modular product not reduced");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_LOAD |=> !found_r && p_r == PW'(2))
    else $error("item load did not clear found and prime index");
`endif

endmodule

`default_nettype wire

### rtl/core/fmtp_ctrl.sv
// ---------------------------------------------------------------------------
// fmtp_ctrl: controller
// Sequences the table fill, the sieve and the per-item prime walk.
// ---------------------------------------------------------------------------
`default_nettype none

module fmtp_ctrl import fmtp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_FILL,
    ST_SV_RD,
    ST_SV_CHK,
    ST_SV_MARK,
    ST_IDLE,
    ST_PLOOP,
    ST_PCHK,
    ST_QDIV,
    ST_QWAIT,
    ST_ECHK,
    ST_KWAIT,
    ST_BASE,
    ST_BWAIT,
    ST_POW,
    ST_RBWAIT,
    ST_BB,
    ST_BBWAIT,
    ST_AWAIT,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.rd_i  = 1'b0;
    case (state_r)
      ST_FILL: begin
        cmd.op = OP_FILL;
        if (stat.fill_last) begin
          state_nxt = ST_SV_RD;
        end
      end
      ST_SV_RD: begin
        cmd.rd_i  = 1'b1;
        state_nxt = ST_SV_CHK;
      end
      ST_SV_CHK: begin
        if (!stat.i_sq_lt) begin
          state_nxt = ST_IDLE;
        end else if (stat.flag) begin
          cmd.op    = OP_SV_JSET;
          state_nxt = ST_SV_MARK;
        end else begin
          cmd.op    = OP_SV_INEXT;
          state_nxt = ST_SV_RD;
        end
      end
      ST_SV_MARK: begin
        if (stat.j_ge) begin
          cmd.op    = OP_SV_INEXT;
          state_nxt = ST_SV_RD;
        end else begin
          cmd.op = OP_SV_MARK;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_PLOOP;
        end
      end
      ST_PLOOP: begin
        state_nxt = stat.p_gt_n ? ST_EMIT : ST_PCHK;
      end
      ST_PCHK: begin
        if (stat.flag) begin
          cmd.op    = OP_QINIT;
          state_nxt = ST_QDIV;
        end else begin
          cmd.op    = OP_PNEXT;
          state_nxt = ST_PLOOP;
        end
      end
      ST_QDIV: begin
        cmd.op    = OP_DIV_Q;
        state_nxt = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_QSTEP;
          state_nxt = stat.quot_zero ? ST_ECHK : ST_QDIV;
        end
      end
      ST_ECHK: begin
        if (!stat.e_ge_t) begin
          cmd.op    = OP_PNEXT;
          state_nxt = ST_PLOOP;
        end else if (stat.m_small) begin
          cmd.op    = OP_FOUND;
          state_nxt = ST_PLOOP;
        end else begin
          cmd.op    = OP_DIV_K;
          state_nxt = ST_KWAIT;
        end
      end
      ST_KWAIT: begin
        if (stat.div_done) begin
          cmd.op    = OP_KSET;
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.op    = OP_MUL_BASE;
        state_nxt = ST_BWAIT;
      end
      ST_BWAIT: begin
        if (stat.mul_done) begin
          cmd.op    = OP_BSET;
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        if (stat.k_zero) begin
          cmd.op    = OP_MUL_ACC;
          state_nxt = ST_AWAIT;
        end else if (stat.k_odd) begin
          cmd.op    = OP_MUL_RB;
          state_nxt = ST_RBWAIT;
        end else begin
          cmd.op    = OP_MUL_BB;
          state_nxt = ST_BBWAIT;
        end
      end
      ST_RBWAIT: begin
        if (stat.mul_done) begin
          cmd.op    = OP_RSET;
          state_nxt = ST_BB;
        end
      end
      ST_BB: begin
        cmd.op    = OP_MUL_BB;
        state_nxt = ST_BBWAIT;
      end
      ST_BBWAIT: begin
        if (stat.mul_done) begin
          cmd.op    = OP_BSQ;
          state_nxt = ST_POW;
        end
      end
      ST_AWAIT: begin
        if (stat.mul_done) begin
          cmd.op    = OP_ACCSET;
          state_nxt = ST_PLOOP;
        end
      end
      ST_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef ASSERT_OFF
  a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && start |=> state_r == ST_PLOOP)
    else $error("accepted beat did not start the prime walk");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |=> state_r == ST_IDLE)
    else $error("result beat not followed by idle");

  a_pow_from_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POW |-> $past(stat.mul_done))
    else $error("power step entered without a finished multiply");
`endif

endmodule

`default_nettype wire

### rtl/core/factorial_max_tth_power_divisor_mod_core.sv
// ---------------------------------------------------------------------------
// factorial_max_tth_power_divisor_mod_core: top level
// Product over primes p <= n of p^(e(p)/t) mod modulus, e(p) from Legendre.
//
//   channel  ports                                handshake
//   input    in_n_value, in_power_t               start && !busy
//   result   out_found, out_product               out_valid, one cycle
//   config   cfg_wdata                            cfg_we
//
// After reset the table is filled, then the sieve marks multiples from p*p
// of each prime p below sqrt(MAX_N); busy is high meanwhile.
// From the accepting edge an item visits each integer from 2 to n; each
// prime p <= n takes log_p(n)+1 divider passes; each qualifying prime
// (e >= t) takes, unless modulus is below two, one more pass for e/t and
// 2 + bits(e/t) + ones(e/t) modular multiplies. The divider and the
// bit-serial multiplier set the run time. No stall: results are not held off.
// ---------------------------------------------------------------------------
`default_nettype none

module factorial_max_tth_power_divisor_mod_core import fmtp_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [NW-1:0] in_n_value,
  input  wire logic [NW-1:0] in_power_t,
  output logic               out_valid,
  output logic               out_found,
  output logic      [MW-1:0] out_product,
  input  wire logic          cfg_we,
  input  wire logic [MW-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  fmtp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fmtp_dp #(.MAX_N(MAX_N)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_n_value  (in_n_value),
    .in_power_t  (in_power_t),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_found   (out_found),
    .out_product (out_product)
  );

endmodule

`default_nettype wire
